>>> src/stsb_pkg.sv
// Shared constants and codes for the timer slot bank.
// Used by software_timer_slot_bank_unit; depends on nothing.
`default_nettype none

package stsb_pkg;

   // Bank size and reporting limit
   localparam int SLOT_COUNT  = 16;
   localparam int MAX_RESULTS = 16;

   // Derived widths
   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SWEEP_W = $clog2(SLOT_COUNT + 1);
   localparam int FIRE_W  = $clog2(MAX_RESULTS + 1);

   // Field widths
   localparam int ACTION_W = 3;
   localparam int ID_W     = 5;
   localparam int TIME_W   = 16;
   localparam int KIND_W   = 3;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [TIME_W-1:0]   time_type;

   // Action codes
   localparam action_type ACT_TICK       = 3'd0;
   localparam action_type ACT_ALLOC      = 3'd1;
   localparam action_type ACT_RELEASE    = 3'd2;
   localparam action_type ACT_SET_PERIOD = 3'd3;
   localparam action_type ACT_ADD_COUNT  = 3'd4;
   localparam action_type ACT_ZERO_COUNT = 3'd5;
   localparam action_type ACT_QUERY_USED = 3'd6;
   localparam action_type ACT_SCAN       = 3'd7;

   // Result kinds
   localparam kind_type RES_ALLOCATED   = 3'd0;
   localparam kind_type RES_ALLOC_FAIL  = 3'd1;
   localparam kind_type RES_FIRED       = 3'd2;
   localparam kind_type RES_NONE_FIRED  = 3'd3;
   localparam kind_type RES_USED_STATUS = 3'd4;
   localparam kind_type RES_DONE        = 3'd5;
   localparam kind_type RES_BAD_ID      = 3'd6;

endpackage

`default_nettype wire

>>> src/software_timer_slot_bank_unit.sv
// Timer slot bank: command decode, slot sweep and result generation.
// Depends on stsb_pkg.
`default_nettype none

// A command is taken at a clock edge where start is high and busy is low. Allocate,
// release, set period, zero count, query used and add count with an out-of-range id
// finish without raising busy; add count with a valid id passes through ST_ADD (read,
// then write back of the counter). Tick and scan walk the counter memory one slot per
// cycle through its single read port and hold busy until the closing result. Each
// result is driven for one cycle with rsp_valid high, registered into the cycle after
// the one that produced it; there is no way to hold results off, so they must be
// captured when shown. A scan may produce one fire result per cycle, the final one
// marked with rsp_last. No clearing pass is needed after reset.
module software_timer_slot_bank_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [stsb_pkg::ACTION_W-1:0]    req_action,
   input  wire  [stsb_pkg::ID_W-1:0]        req_timer_id,
   input  wire  [stsb_pkg::TIME_W-1:0]      req_time_value,
   output logic                             rsp_valid,
   output logic [stsb_pkg::KIND_W-1:0]      rsp_result_kind,
   output logic [stsb_pkg::ID_W-1:0]        rsp_slot_index,
   output logic                             rsp_used_flag,
   output logic                             rsp_last
);
   import stsb_pkg::*;

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ADD   = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   // Control registers
   logic [1:0]            state_ff, state_in;
   logic [SWEEP_W-1:0]    sw_ff, sw_in;
   logic                  p_act_ff, p_act_in;
   logic [SLOT_W-1:0]     p_idx_ff, p_idx_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [SLOT_COUNT-1:0] cnt_vld_ff;
   logic                  pend_vld_ff, pend_vld_in;
   logic [FIRE_W-1:0]     fire_cnt_ff, fire_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   action_type            op_ff, op_in;
   logic [ID_W-1:0]       id_ff, id_in;
   time_type              tv_ff, tv_in;
   logic [SLOT_W-1:0]     pend_idx_ff, pend_idx_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]       rsp_idx_ff, rsp_idx_in;
   logic                  rsp_used_ff, rsp_used_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Memories and their ports
   time_type              cnt_mem [SLOT_COUNT];
   time_type              per_mem [SLOT_COUNT];
   time_type              cnt_rd_ff;
   time_type              per_rd_ff;
   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  cnt_we;
   logic [SLOT_W-1:0]     cnt_wa;
   time_type              cnt_wd;
   logic                  per_we;
   logic [SLOT_W-1:0]     per_wa;

   // Decode helpers
   logic                  id_ok;
   logic [SLOT_W-1:0]     req_slot;
   logic                  free_any;
   logic [SLOT_W-1:0]     free_idx;
   time_type              cnt_val;
   logic                  fire;

   assign id_ok    = (32'(req_timer_id) < SLOT_COUNT);
   assign req_slot = req_timer_id[SLOT_W-1:0];

   // A counter entry never written since reset reads as zero
   assign cnt_val = cnt_vld_ff[p_idx_ff] ? cnt_rd_ff : '0;
   assign fire    = used_ff[p_idx_ff] && (cnt_val == '0);

   // Lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // Sequencer and result generation
   always_comb begin
      state_in     = state_ff;
      sw_in        = sw_ff;
      p_act_in     = 1'b0;
      p_idx_in     = p_idx_ff;
      used_in      = used_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      fire_cnt_in  = fire_cnt_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      tv_in        = tv_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = RES_DONE;
      rsp_idx_in   = '0;
      rsp_used_in  = 1'b0;
      rsp_last_in  = 1'b1;
      rd_en        = 1'b0;
      rd_addr      = '0;
      cnt_we       = 1'b0;
      cnt_wa       = p_idx_ff;
      cnt_wd       = '0;
      per_we       = 1'b0;
      per_wa       = req_slot;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in = req_action;
               id_in = req_timer_id;
               tv_in = req_time_value;
               case (req_action)
                  ACT_TICK, ACT_SCAN: begin
                     state_in    = ST_SWEEP;
                     sw_in       = '0;
                     pend_vld_in = 1'b0;
                     fire_cnt_in = '0;
                  end
                  ACT_ALLOC: begin
                     rsp_valid_in = 1'b1;
                     if (free_any) begin
                        used_in[free_idx] = 1'b1;
                        per_we       = 1'b1;
                        per_wa       = free_idx;
                        cnt_we       = 1'b1;
                        cnt_wa       = free_idx;
                        rsp_kind_in  = RES_ALLOCATED;
                        rsp_idx_in   = ID_W'(free_idx);
                     end else begin
                        rsp_kind_in  = RES_ALLOC_FAIL;
                        rsp_idx_in   = req_timer_id;
                     end
                  end
                  default: begin
                     rsp_idx_in = req_timer_id;
                     if (!id_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = RES_BAD_ID;
                     end else begin
                        case (req_action)
                           ACT_RELEASE: begin
                              used_in[req_slot] = 1'b0;
                              rsp_valid_in      = 1'b1;
                           end
                           ACT_SET_PERIOD: begin
                              per_we       = 1'b1;
                              rsp_valid_in = 1'b1;
                           end
                           ACT_ADD_COUNT: begin
                              rd_en    = 1'b1;
                              rd_addr  = req_slot;
                              p_idx_in = req_slot;
                              state_in = ST_ADD;
                           end
                           ACT_ZERO_COUNT: begin
                              cnt_we       = 1'b1;
                              cnt_wa       = req_slot;
                              rsp_valid_in = 1'b1;
                           end
                           default: begin
                              rsp_valid_in = 1'b1;
                              rsp_kind_in  = RES_USED_STATUS;
                              rsp_used_in  = used_ff[req_slot];
                           end
                        endcase
                     end
                  end
               endcase
            end
         end

         // Counter read came back: add with 16-bit wrap, write back
         ST_ADD: begin
            cnt_we       = 1'b1;
            cnt_wd       = cnt_val + tv_ff;
            rsp_valid_in = 1'b1;
            rsp_idx_in   = id_ff;
            state_in     = ST_IDLE;
         end

         ST_SWEEP: begin
            // Issue side: one slot read per cycle
            if (sw_ff < SWEEP_W'(SLOT_COUNT)) begin
               rd_en    = 1'b1;
               rd_addr  = sw_ff[SLOT_W-1:0];
               p_act_in = 1'b1;
               p_idx_in = sw_ff[SLOT_W-1:0];
               sw_in    = sw_ff + 1'b1;
            end
            // Process side: data for slot p_idx_ff
            if (p_act_ff) begin
               if (op_ff == ACT_TICK) begin
                  if (cnt_val != '0) begin
                     cnt_we = 1'b1;
                     cnt_wd = cnt_val - 1'b1;
                  end
               end else if (fire) begin
                  cnt_we = 1'b1;
                  cnt_wd = per_rd_ff;
                  // Hold the newest fire back until we know whether it is the last
                  if (32'(fire_cnt_ff) < MAX_RESULTS) begin
                     if (pend_vld_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = RES_FIRED;
                        rsp_idx_in   = ID_W'(pend_idx_ff);
                        rsp_last_in  = 1'b0;
                     end
                     pend_vld_in = 1'b1;
                     pend_idx_in = p_idx_ff;
                     fire_cnt_in = fire_cnt_ff + 1'b1;
                  end
               end
            end else if (sw_ff == SWEEP_W'(SLOT_COUNT)) begin
               // Sweep finished: closing result
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == ACT_TICK) begin
                  rsp_kind_in = RES_DONE;
                  rsp_idx_in  = id_ff;
               end else if (pend_vld_ff) begin
                  rsp_kind_in = RES_FIRED;
                  rsp_idx_in  = ID_W'(pend_idx_ff);
               end else begin
                  rsp_kind_in = RES_NONE_FIRED;
                  rsp_idx_in  = '0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sw_ff        <= '0;
         p_act_ff     <= 1'b0;
         used_ff      <= '0;
         cnt_vld_ff   <= '0;
         pend_vld_ff  <= 1'b0;
         fire_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         p_act_ff     <= p_act_in;
         used_ff      <= used_in;
         pend_vld_ff  <= pend_vld_in;
         fire_cnt_ff  <= fire_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            cnt_vld_ff[cnt_wa] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      tv_ff       <= tv_in;
      p_idx_ff    <= p_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_used_ff <= rsp_used_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Counter and period memories, registered read
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (per_we) begin
         per_mem[per_wa] <= tv_in;
      end
      if (rd_en) begin
         cnt_rd_ff <= cnt_mem[rd_addr];
         per_rd_ff <= per_mem[rd_addr];
      end
   end

   // Outputs
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_slot_index  = rsp_idx_ff;
   assign rsp_used_flag   = rsp_used_ff;
   assign rsp_last        = rsp_last_ff;

   // Checks
   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      32'(fire_cnt_ff) <= MAX_RESULTS)
      else $error("fire count past reporting limit");

   a_mid_result_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> state_ff == ST_SWEEP)
      else $error("non-final result outside a sweep");

   a_fire_from_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == RES_FIRED |-> $past(state_ff) == ST_SWEEP)
      else $error("fire result not produced by a scan");

   a_pipe_after_issue: assert property (@(posedge clock) disable iff (reset)
      p_act_ff |-> state_ff == ST_SWEEP && sw_ff != '0)
      else $error("sweep data stage active without an issued read");

   a_add_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("add count did not complete");

endmodule

`default_nettype wire
